>>> src/ledger_binary_field_parser_macros.svh
// ----------------------------------------------------------------------------
// ledger_binary_field_parser_macros
// Assertion macros shared by the ledger field parser. They expect clk and
// rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef LEDGER_BINARY_FIELD_PARSER_MACROS_SVH
`define LEDGER_BINARY_FIELD_PARSER_MACROS_SVH

// same-cycle implication
`define LBFP_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbfp same-cycle check failed");

// next-cycle implication
`define LBFP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbfp next-cycle check failed");

`endif

>>> src/lbfp_pkg.sv
// ----------------------------------------------------------------------------
// lbfp_pkg
// Types, codes and size table for the ledger binary field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfp_pkg;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_H3      = 7'b0000010,
    PH_HTYPE   = 7'b0000100,
    PH_HFIELD  = 7'b0001000,
    PH_LEN     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DRAIN   = 7'b1000000
  } phase_t;

  // event kinds
  localparam logic [3:0] EV_HDR_PART  = 4'd0;
  localparam logic [3:0] EV_HDR_DONE  = 4'd1;
  localparam logic [3:0] EV_LEN       = 4'd2;
  localparam logic [3:0] EV_PAYLOAD   = 4'd3;
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd4;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd5;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd6;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd7;
  localparam logic [3:0] EV_IGNORED   = 4'd8;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TYPE_ZERO  = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd2;
  localparam logic [2:0] ERR_UNMATCHED  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd4;
  localparam logic [2:0] ERR_DEPTH      = 3'd5;
  localparam logic [2:0] ERR_PATHSET    = 3'd6;

  // type codes
  localparam logic [7:0] TY_NONE      = 8'd0;
  localparam logic [7:0] TY_UINT16    = 8'd1;
  localparam logic [7:0] TY_UINT32    = 8'd2;
  localparam logic [7:0] TY_UINT64    = 8'd3;
  localparam logic [7:0] TY_HASH128   = 8'd4;
  localparam logic [7:0] TY_HASH256   = 8'd5;
  localparam logic [7:0] TY_AMOUNT    = 8'd6;
  localparam logic [7:0] TY_BLOB      = 8'd7;
  localparam logic [7:0] TY_ACCOUNT   = 8'd8;
  localparam logic [7:0] TY_OBJECT    = 8'd14;
  localparam logic [7:0] TY_ARRAY     = 8'd15;
  localparam logic [7:0] TY_UINT8     = 8'd16;
  localparam logic [7:0] TY_HASH160   = 8'd17;
  localparam logic [7:0] TY_PATHSET   = 8'd18;
  localparam logic [7:0] TY_VECTOR256 = 8'd19;

  // field code that closes an object or array
  localparam logic [7:0] FIELD_END = 8'd1;

  // length prefix thresholds
  localparam logic [7:0]  LEN_ONE_MAX    = 8'd192;
  localparam logic [7:0]  LEN_TWO_MAX    = 8'd240;
  localparam logic [7:0]  LEN_THREE_MAX  = 8'd254;
  localparam logic [19:0] LEN_TWO_BASE   = 20'd193;
  localparam logic [7:0]  LEN_THREE_LEAD = 8'd241;
  localparam logic [19:0] LEN_THREE_BASE = 20'd12481;

  // amounts
  localparam logic [19:0] AMT_ISSUED_LEN = 20'd48;
  localparam logic [19:0] AMT_MANT_END   = 20'd7;

  // combined nesting limit
  localparam logic [8:0] MAX_DEPTH = 9'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [7:0]  type_id;
    logic [7:0]  field_id;
    logic [7:0]  payload_byte;
    logic [19:0] byte_index;
    logic        last_of_field;
    logic [63:0] int_value;
    logic        is_negative;
    logic [2:0]  error_code;
    logic [7:0]  nesting_depth;
    logic        last_of_message;
  } out_item_t;

  // payload size of fixed types, zero for types without one
  function automatic logic [5:0] fixed_size(input logic [7:0] t);
    logic [5:0] sz;
    case (t)
      TY_UINT16:  sz = 6'd2;
      TY_UINT32:  sz = 6'd4;
      TY_UINT64:  sz = 6'd8;
      TY_HASH128: sz = 6'd16;
      TY_HASH256: sz = 6'd32;
      TY_AMOUNT:  sz = 6'd8;
      TY_ACCOUNT: sz = 6'd21;
      TY_UINT8:   sz = 6'd1;
      TY_HASH160: sz = 6'd20;
      default:    sz = 6'd0;
    endcase
    return sz;
  endfunction

endpackage

`default_nettype wire

>>> src/lbfp_in_if.sv
// ----------------------------------------------------------------------------
// lbfp_in_if
// Byte channel into the parser: valid, ready and one input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbfp_in_if;
  logic               valid;
  logic               ready;
  lbfp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/lbfp_out_if.sv
// ----------------------------------------------------------------------------
// lbfp_out_if
// Result channel out of the parser: valid, ready and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbfp_out_if;
  logic                valid;
  logic                ready;
  lbfp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/lbfp_in_stage.sv
// ----------------------------------------------------------------------------
// lbfp_in_stage
// Input register. Holds one byte until the parse stage can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  lbfp_in_if.sink            in_ch,
  input  logic               take,
  output logic               item_valid,
  output lbfp_pkg::in_item_t item
);

  logic               valid_r;
  lbfp_pkg::in_item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.payload;
    end
  end

endmodule

`default_nettype wire

>>> src/lbfp_parse.sv
// ----------------------------------------------------------------------------
// lbfp_parse
// Parser state and the per-byte step: header decode, length prefix,
// payload counting, value assembly, nesting and sticky error.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  lbfp_pkg::in_item_t  item,
  output lbfp_pkg::out_item_t result
);

  typedef struct packed {
    lbfp_pkg::phase_t phase;
    logic [15:0]      header_bytes;
    logic [7:0]       cur_type;
    logic [7:0]       cur_field;
    logic [19:0]      bytes_left;
    logic [19:0]      pos;
    logic [63:0]      acc;
    logic [7:0]       obj_depth;
    logic [7:0]       arr_depth;
    logic [2:0]       err;
  } pstate_t;

  localparam pstate_t ST_RESET = '{
    phase:        lbfp_pkg::PH_IDLE,
    header_bytes: 16'h0000,
    cur_type:     8'h00,
    cur_field:    8'h00,
    bytes_left:   20'h00000,
    pos:          20'h00000,
    acc:          64'h0,
    obj_depth:    8'h00,
    arr_depth:    8'h00,
    err:          lbfp_pkg::ERR_NONE
  };

  pstate_t     st_r;
  pstate_t     st_nxt;

  logic [7:0]  b;
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [8:0]  depth_sum;
  logic        hdr_go;
  logic [7:0]  hdr_t;
  logic [7:0]  hdr_f;
  logic        is_obj;
  logic [5:0]  hdr_size;
  logic        len_done;
  logic [19:0] len_val;
  logic [7:0]  lead_two;
  logic [7:0]  lead_three;
  logic [19:0] left_base;
  logic [19:0] left_dec;
  logic [15:0] amt_hb;
  logic        first;
  logic [3:0]  ev;
  logic        last;
  logic        neg;
  logic [19:0] idx;
  logic [63:0] ival;
  logic        ignored;

  assign b          = item.data_byte;
  assign hi         = b[7:4];
  assign lo         = b[3:0];
  assign depth_sum  = {1'b0, st_r.obj_depth} + {1'b0, st_r.arr_depth};
  assign is_obj     = (hdr_t == lbfp_pkg::TY_OBJECT);
  assign hdr_size   = lbfp_pkg::fixed_size(hdr_t);
  assign first      = (st_r.pos == 20'd0);
  assign lead_two   = st_r.header_bytes[7:0] - lbfp_pkg::LEN_TWO_BASE[7:0];
  assign lead_three = st_r.header_bytes[15:8] - lbfp_pkg::LEN_THREE_LEAD;

  always_comb begin
    st_nxt    = st_r;
    ev        = lbfp_pkg::EV_HDR_PART;
    last      = 1'b0;
    neg       = 1'b0;
    idx       = 20'd0;
    ival      = 64'd0;
    ignored   = 1'b0;
    hdr_go    = 1'b0;
    hdr_t     = lbfp_pkg::TY_NONE;
    hdr_f     = 8'd0;
    len_done  = 1'b0;
    len_val   = 20'd0;
    left_base = st_r.bytes_left;
    left_dec  = 20'd0;
    amt_hb    = st_r.header_bytes;

    case (st_r.phase)
      lbfp_pkg::PH_H3: begin
        st_nxt.header_bytes = {st_r.header_bytes[7:0], b};
        st_nxt.cur_type     = b;
        st_nxt.phase        = lbfp_pkg::PH_HFIELD;
      end
      lbfp_pkg::PH_HTYPE: begin
        st_nxt.header_bytes = {st_r.header_bytes[7:0], b};
        hdr_go = 1'b1;
        hdr_t  = b;
        hdr_f  = st_r.cur_field;
      end
      lbfp_pkg::PH_HFIELD: begin
        st_nxt.header_bytes = {st_r.header_bytes[7:0], b};
        hdr_go = 1'b1;
        hdr_t  = st_r.cur_type;
        hdr_f  = b;
      end
      lbfp_pkg::PH_LEN: begin
        ev = lbfp_pkg::EV_LEN;
        if (first) begin
          if (b <= lbfp_pkg::LEN_ONE_MAX) begin
            len_val  = {12'h000, b};
            len_done = 1'b1;
          end else if (b <= lbfp_pkg::LEN_THREE_MAX) begin
            st_nxt.header_bytes = {8'h00, b};
            st_nxt.pos          = 20'd1;
          end else begin
            st_nxt.err   = lbfp_pkg::ERR_UNKNOWN;
            st_nxt.phase = lbfp_pkg::PH_DRAIN;
          end
        end else if (st_r.pos == 20'd1) begin
          if (st_r.header_bytes[7:0] <= lbfp_pkg::LEN_TWO_MAX) begin
            len_val  = lbfp_pkg::LEN_TWO_BASE + {4'h0, lead_two, b};
            len_done = 1'b1;
          end else begin
            st_nxt.header_bytes = {st_r.header_bytes[7:0], b};
            st_nxt.pos          = 20'd2;
          end
        end else begin
          len_val  = lbfp_pkg::LEN_THREE_BASE
                   + {lead_three[3:0], st_r.header_bytes[7:0], b};
          len_done = 1'b1;
        end
        if (len_done) begin
          st_nxt.pos = 20'd0;
          if (len_val == 20'd0) begin
            last         = 1'b1;
            st_nxt.phase = lbfp_pkg::PH_IDLE;
          end else begin
            st_nxt.bytes_left = len_val;
            st_nxt.phase      = lbfp_pkg::PH_PAYLOAD;
          end
        end
      end
      lbfp_pkg::PH_PAYLOAD: begin
        ev  = lbfp_pkg::EV_PAYLOAD;
        idx = st_r.pos;
        if (st_r.cur_type == lbfp_pkg::TY_AMOUNT) begin
          if (first) begin
            amt_hb              = {8'h00, b};
            st_nxt.header_bytes = {8'h00, b};
            if (b[7]) begin
              left_base = lbfp_pkg::AMT_ISSUED_LEN;
            end
          end
          if (!amt_hb[7]) begin
            st_nxt.acc = first ? {58'd0, b[5:0]} : {st_r.acc[55:0], b};
          end else if (first) begin
            st_nxt.acc = 64'd0;
          end else if (st_r.pos == 20'd1) begin
            st_nxt.acc = {58'd0, b[5:0]};
          end else if (st_r.pos <= lbfp_pkg::AMT_MANT_END) begin
            st_nxt.acc = {st_r.acc[55:0], b};
          end
          neg  = !amt_hb[6];
          ival = st_nxt.acc;
        end else if (st_r.cur_type inside {lbfp_pkg::TY_UINT16, lbfp_pkg::TY_UINT32,
                                           lbfp_pkg::TY_UINT64, lbfp_pkg::TY_UINT8}) begin
          st_nxt.acc = {st_r.acc[55:0], b};
          ival       = st_nxt.acc;
        end
        left_dec          = (left_base != 20'd0) ? left_base - 20'd1 : 20'd0;
        st_nxt.bytes_left = left_dec;
        st_nxt.pos        = st_r.pos + 20'd1;
        if (left_dec == 20'd0) begin
          last         = 1'b1;
          st_nxt.phase = lbfp_pkg::PH_IDLE;
        end
      end
      lbfp_pkg::PH_DRAIN: begin
        ignored = 1'b1;
        ev      = lbfp_pkg::EV_IGNORED;
      end
      default: begin
        st_nxt.header_bytes = {8'h00, b};
        if (b == 8'h00) begin
          st_nxt.cur_type  = lbfp_pkg::TY_NONE;
          st_nxt.cur_field = 8'h00;
          st_nxt.phase     = lbfp_pkg::PH_H3;
        end else if (hi == 4'h0) begin
          st_nxt.cur_type  = lbfp_pkg::TY_NONE;
          st_nxt.cur_field = {4'h0, lo};
          st_nxt.phase     = lbfp_pkg::PH_HTYPE;
        end else if (lo == 4'h0) begin
          st_nxt.cur_type  = {4'h0, hi};
          st_nxt.cur_field = 8'h00;
          st_nxt.phase     = lbfp_pkg::PH_HFIELD;
        end else begin
          hdr_go = 1'b1;
          hdr_t  = {4'h0, hi};
          hdr_f  = {4'h0, lo};
        end
      end
    endcase

    // header complete
    if (hdr_go) begin
      st_nxt.cur_type  = hdr_t;
      st_nxt.cur_field = hdr_f;
      ev               = lbfp_pkg::EV_HDR_DONE;
      if (hdr_t == lbfp_pkg::TY_NONE) begin
        st_nxt.err   = lbfp_pkg::ERR_TYPE_ZERO;
        st_nxt.phase = lbfp_pkg::PH_DRAIN;
      end else if (hdr_t == lbfp_pkg::TY_PATHSET) begin
        st_nxt.err   = lbfp_pkg::ERR_PATHSET;
        st_nxt.phase = lbfp_pkg::PH_DRAIN;
      end else if (hdr_t == lbfp_pkg::TY_OBJECT || hdr_t == lbfp_pkg::TY_ARRAY) begin
        st_nxt.phase = lbfp_pkg::PH_IDLE;
        if (hdr_f == lbfp_pkg::FIELD_END) begin
          ev = is_obj ? lbfp_pkg::EV_OBJ_CLOSE : lbfp_pkg::EV_ARR_CLOSE;
          if ((is_obj ? st_r.obj_depth : st_r.arr_depth) == 8'd0) begin
            st_nxt.err   = lbfp_pkg::ERR_UNMATCHED;
            st_nxt.phase = lbfp_pkg::PH_DRAIN;
          end else begin
            if (is_obj) begin
              st_nxt.obj_depth = st_r.obj_depth - 8'd1;
            end else begin
              st_nxt.arr_depth = st_r.arr_depth - 8'd1;
            end
            last = 1'b1;
          end
        end else begin
          ev = is_obj ? lbfp_pkg::EV_OBJ_OPEN : lbfp_pkg::EV_ARR_OPEN;
          if (depth_sum >= lbfp_pkg::MAX_DEPTH) begin
            st_nxt.err   = lbfp_pkg::ERR_DEPTH;
            st_nxt.phase = lbfp_pkg::PH_DRAIN;
          end else begin
            if (is_obj) begin
              st_nxt.obj_depth = st_r.obj_depth + 8'd1;
            end else begin
              st_nxt.arr_depth = st_r.arr_depth + 8'd1;
            end
            last = 1'b1;
          end
        end
      end else if (hdr_t == lbfp_pkg::TY_BLOB || hdr_t == lbfp_pkg::TY_VECTOR256) begin
        st_nxt.phase        = lbfp_pkg::PH_LEN;
        st_nxt.pos          = 20'd0;
        st_nxt.header_bytes = 16'h0000;
      end else if (hdr_size == 6'd0) begin
        st_nxt.err   = lbfp_pkg::ERR_UNKNOWN;
        st_nxt.phase = lbfp_pkg::PH_DRAIN;
      end else begin
        st_nxt.phase      = lbfp_pkg::PH_PAYLOAD;
        st_nxt.bytes_left = {14'd0, hdr_size};
        st_nxt.pos        = 20'd0;
        st_nxt.acc        = 64'd0;
      end
    end

    // end of message inside a field
    if (item.end_of_message && st_nxt.err == lbfp_pkg::ERR_NONE
        && st_nxt.phase != lbfp_pkg::PH_IDLE) begin
      st_nxt.err = lbfp_pkg::ERR_TRUNCATED;
    end

    result.event_kind      = ev;
    result.type_id         = ignored ? 8'h00 : st_nxt.cur_type;
    result.field_id        = ignored ? 8'h00 : st_nxt.cur_field;
    result.payload_byte    = b;
    result.byte_index      = idx;
    result.last_of_field   = last;
    result.int_value       = ival;
    result.is_negative     = neg;
    result.error_code      = st_nxt.err;
    result.nesting_depth   = st_nxt.obj_depth + st_nxt.arr_depth;
    result.last_of_message = item.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (fire) begin
      st_r <= item.end_of_message ? ST_RESET : st_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/lbfp_out_stage.sv
// ----------------------------------------------------------------------------
// lbfp_out_stage
// Result register. Loads whenever it is empty or its result is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  input  lbfp_pkg::out_item_t result,
  output logic                can_load,
  lbfp_out_if.source          out_ch
);

  logic                valid_r;
  lbfp_pkg::out_item_t item_r;

  assign can_load      = !valid_r || out_ch.ready;
  assign out_ch.valid   = valid_r;
  assign out_ch.payload = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      item_r <= result;
    end
  end

endmodule

`default_nettype wire

>>> src/ledger_binary_field_parser.sv
// ----------------------------------------------------------------------------
// ledger_binary_field_parser
// Streaming parser for serialized ledger objects, one byte per transfer.
//
// in_ch carries one raw byte and an end-of-message flag per transfer; out_ch
// returns exactly one classified result per input byte, in order: event kind,
// current type and field codes, the byte, its position in the field, field
// end, assembled integer or amount magnitude, amount sign, sticky error,
// nesting depth and the end-of-message echo.
// A result passes the input register, the parse step and the result register,
// in that order, before it is valid on out_ch.
// Throughput: one byte per cycle while out_ch takes results, set by the single
// parse step between the two registers; the parser state updates once per byte.
// When out_ch stalls, the result register holds and the input register
// takes one more byte; in_ch.ready then drops until out_ch moves again.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to waiting for a field header. A byte flagged end of message
// does the same after its result is formed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ledger_binary_field_parser_macros.svh"

module ledger_binary_field_parser (
  input  logic       clk,
  input  logic       rst_n,
  lbfp_in_if.sink    in_ch,
  lbfp_out_if.source out_ch
);

  logic                item_valid;
  lbfp_pkg::in_item_t  item;
  logic                can_load;
  logic                fire;
  lbfp_pkg::out_item_t result;

  assign fire = item_valid && can_load;

  lbfp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  lbfp_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  lbfp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (item_valid),
    .result     (result),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

  `LBFP_ASSERT_NEXT(a_accept_fills_input, in_ch.valid && in_ch.ready, item_valid)
  `LBFP_ASSERT_NEXT(a_step_fills_output, fire, out_ch.valid)
  `LBFP_ASSERT_IMPLY(a_ignored_needs_error, out_ch.valid && out_ch.payload.event_kind == lbfp_pkg::EV_IGNORED, out_ch.payload.error_code != lbfp_pkg::ERR_NONE)
  `LBFP_ASSERT_IMPLY(a_value_on_payload_only, out_ch.valid && out_ch.payload.event_kind != lbfp_pkg::EV_PAYLOAD, out_ch.payload.int_value == 64'd0)

endmodule

`default_nettype wire

>>> tb/lbfp_parse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfp_parse_checker
// Watches both channels of the ledger field parser. Every accepted input byte
// is run through a cycle-free parser that follows the header, length prefix,
// payload, nesting and sticky error rules. The classified result is queued,
// and each result leaving the block is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module lbfp_parse_checker import lbfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lbfp_in_if         in_ch,
  lbfp_out_if        out_ch,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output logic [8:0] ev_seen,
  output logic [7:0] err_seen
);

  phase_t      ph;
  logic [15:0] hdr;
  logic [7:0]  cur_ty;
  logic [7:0]  cur_fld;
  logic [19:0] left;
  logic [19:0] pos;
  logic [63:0] acc;
  logic [7:0]  obj_d;
  logic [7:0]  arr_d;
  logic [2:0]  err;

  out_item_t classified_q[$];

  task automatic reset_parser();
    ph = PH_IDLE;
    hdr = '0;
    cur_ty = '0;
    cur_fld = '0;
    left = '0;
    pos = '0;
    acc = '0;
    obj_d = '0;
    arr_d = '0;
    err = ERR_NONE;
  endtask

  function automatic logic [19:0] field_bytes(input logic [7:0] t);
    case (t)
      TY_UINT8:                return 20'd1;
      TY_UINT16:               return 20'd2;
      TY_UINT32:               return 20'd4;
      TY_UINT64, TY_AMOUNT:    return 20'd8;
      TY_HASH128:              return 20'd16;
      TY_HASH160:              return 20'd20;
      TY_ACCOUNT:              return 20'd21;
      TY_HASH256:              return 20'd32;
      default:                 return 20'd0;
    endcase
  endfunction

  task automatic set_error(input logic [2:0] code);
    err = code;
    ph = PH_DRAIN;
  endtask

  task automatic finish_header(input logic [7:0] t, input logic [7:0] f,
                               output logic [3:0] ev, output logic last);
    logic [8:0] sum;
    logic       is_obj;
    sum = obj_d + arr_d;
    is_obj = (t == TY_OBJECT);
    cur_ty = t;
    cur_fld = f;
    ev = EV_HDR_DONE;
    last = 1'b0;
    if (t == TY_NONE) begin
      set_error(ERR_TYPE_ZERO);
    end else if (t == TY_PATHSET) begin
      set_error(ERR_PATHSET);
    end else if (t == TY_OBJECT || t == TY_ARRAY) begin
      ph = PH_IDLE;
      if (f == FIELD_END) begin
        ev = is_obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
        if ((is_obj ? obj_d : arr_d) == 8'd0) begin
          set_error(ERR_UNMATCHED);
        end else begin
          if (is_obj) obj_d = obj_d - 8'd1;
          else arr_d = arr_d - 8'd1;
          last = 1'b1;
        end
      end else begin
        ev = is_obj ? EV_OBJ_OPEN : EV_ARR_OPEN;
        if (sum >= 9'd255) begin
          set_error(ERR_DEPTH);
        end else begin
          if (is_obj) obj_d = obj_d + 8'd1;
          else arr_d = arr_d + 8'd1;
          last = 1'b1;
        end
      end
    end else if (t == TY_BLOB || t == TY_VECTOR256) begin
      ph = PH_LEN;
      pos = '0;
      hdr = '0;
    end else if (field_bytes(t) == 20'd0) begin
      set_error(ERR_UNKNOWN);
    end else begin
      ph = PH_PAYLOAD;
      left = field_bytes(t);
      pos = '0;
      acc = '0;
    end
  endtask

  task automatic classify_byte(input in_item_t it, output out_item_t r);
    logic [7:0]  b;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  hi8;
    logic        eom;
    logic        last;
    logic        neg;
    logic        ign;
    logic        done;
    logic [3:0]  ev;
    logic [19:0] idx;
    logic [19:0] len;
    logic [63:0] ival;
    b = it.data_byte;
    eom = it.end_of_message;
    ev = EV_HDR_PART;
    last = 1'b0;
    neg = 1'b0;
    ign = 1'b0;
    done = 1'b0;
    idx = '0;
    len = '0;
    ival = '0;
    case (ph)
      PH_H3: begin
        hdr = {hdr[7:0], b};
        cur_ty = b;
        ph = PH_HFIELD;
      end
      PH_HTYPE: begin
        hdr = {hdr[7:0], b};
        finish_header(b, cur_fld, ev, last);
      end
      PH_HFIELD: begin
        hdr = {hdr[7:0], b};
        finish_header(cur_ty, b, ev, last);
      end
      PH_LEN: begin
        ev = EV_LEN;
        if (pos == 20'd0) begin
          // one-byte length up to 192, 193..254 lead a longer prefix
          if (b <= 8'd192) begin
            len = {12'd0, b};
            done = 1'b1;
          end else if (b <= 8'd254) begin
            hdr = {8'd0, b};
            pos = 20'd1;
          end else begin
            set_error(ERR_UNKNOWN);
          end
        end else if (pos == 20'd1) begin
          b1 = hdr[7:0];
          if (b1 <= 8'd240) begin
            hi8 = b1 - 8'd193;
            len = 20'd193 + {4'd0, hi8, b};
            done = 1'b1;
          end else begin
            hdr = {b1, b};
            pos = 20'd2;
          end
        end else begin
          b1 = hdr[15:8];
          b2 = hdr[7:0];
          hi8 = b1 - 8'd241;
          len = 20'd12481 + {hi8[3:0], b2, b};
          done = 1'b1;
        end
        if (done) begin
          pos = '0;
          if (len == 20'd0) begin
            last = 1'b1;
            ph = PH_IDLE;
          end else begin
            left = len;
            ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        ev = EV_PAYLOAD;
        idx = pos;
        if (cur_ty == TY_AMOUNT) begin
          if (pos == 20'd0) begin
            hdr = {8'd0, b};
            if (b[7]) left = 20'd48;
          end
          // native: 62-bit magnitude, issued: 54-bit mantissa from byte 1
          if (!hdr[7]) acc = (pos == 20'd0) ? {58'd0, b[5:0]} : {acc[55:0], b};
          else if (pos == 20'd0) acc = '0;
          else if (pos == 20'd1) acc = {58'd0, b[5:0]};
          else if (pos <= 20'd7) acc = {acc[55:0], b};
          neg = ~hdr[6];
          ival = acc;
        end else if (cur_ty == TY_UINT16 || cur_ty == TY_UINT32 ||
                     cur_ty == TY_UINT64 || cur_ty == TY_UINT8) begin
          acc = {acc[55:0], b};
          ival = acc;
        end
        if (left > 20'd0) left = left - 20'd1;
        pos = pos + 20'd1;
        if (left == 20'd0) begin
          last = 1'b1;
          ph = PH_IDLE;
        end
      end
      PH_DRAIN: begin
        ign = 1'b1;
        ev = EV_IGNORED;
      end
      default: begin
        hdr = {8'd0, b};
        if (b == 8'd0) begin
          cur_ty = '0;
          cur_fld = '0;
          ph = PH_H3;
        end else if (b[7:4] == 4'd0) begin
          cur_ty = '0;
          cur_fld = {4'd0, b[3:0]};
          ph = PH_HTYPE;
        end else if (b[3:0] == 4'd0) begin
          cur_ty = {4'd0, b[7:4]};
          cur_fld = '0;
          ph = PH_HFIELD;
        end else begin
          finish_header({4'd0, b[7:4]}, {4'd0, b[3:0]}, ev, last);
        end
      end
    endcase
    if (eom && err == ERR_NONE && ph != PH_IDLE) err = ERR_TRUNCATED;
    r.event_kind = ev;
    r.type_id = ign ? 8'd0 : cur_ty;
    r.field_id = ign ? 8'd0 : cur_fld;
    r.payload_byte = b;
    r.byte_index = idx;
    r.last_of_field = last;
    r.int_value = ival;
    r.is_negative = neg;
    r.error_code = err;
    r.nesting_depth = obj_d + arr_d;
    r.last_of_message = eom;
    if (eom) reset_parser();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t lbfp_parse_checker: result %0d %s expected %0h actual %0h",
               $time, checked, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    ev_seen = '0;
    err_seen = '0;
    reset_parser();
  end

  always @(posedge clk) begin
    out_item_t nxt;
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      reset_parser();
      classified_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        classify_byte(in_ch.payload, nxt);
        classified_q.push_back(nxt);
        if (nxt.event_kind <= EV_IGNORED) ev_seen[nxt.event_kind] = 1'b1;
        err_seen[nxt.error_code] = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (classified_q.size() == 0) begin
          $display("%0t lbfp_parse_checker: expected no result, actual %0h",
                   $time, got);
          fail_count++;
        end else begin
          want = classified_q.pop_front();
          check_field("event_kind", want.event_kind, got.event_kind);
          check_field("type_id", want.type_id, got.type_id);
          check_field("field_id", want.field_id, got.field_id);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("last_of_field", want.last_of_field, got.last_of_field);
          check_field("int_value", want.int_value, got.int_value);
          check_field("is_negative", want.is_negative, got.is_negative);
          check_field("error_code", want.error_code, got.error_code);
          check_field("nesting_depth", want.nesting_depth, got.nesting_depth);
          check_field("last_of_message", want.last_of_message, got.last_of_message);
          checked++;
        end
      end
    end
    pending = classified_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ledger binary field parser. Directed messages
// cover full-range integers, both amount forms, all length prefix widths,
// nesting to the depth limit and every error. Random messages follow, mostly
// well-formed with random content, plus truncated, erroring and noise
// messages, with random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import lbfp_pkg::*;

  logic clk;
  logic rst_n;
  logic gaps_on;
  logic hold_off;

  int fail_count;
  int pending;
  int checked;
  int bytes_sent;
  int messages;
  logic [8:0] ev_seen;
  logic [7:0] err_seen;

  logic [7:0] msg_q[$];

  lbfp_in_if  in_ch ();
  lbfp_out_if out_ch ();

  ledger_binary_field_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lbfp_parse_checker parse_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .ev_seen    (ev_seen),
    .err_seen   (err_seen)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = gaps_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload.data_byte <= b;
    in_ch.payload.end_of_message <= e;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
    messages++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
  endtask

  // one, two or three header bytes, any encoding the codes allow
  task automatic put_header(input logic [7:0] t, input logic [7:0] f);
    int   form;
    logic t_nib;
    logic f_nib;
    t_nib = (t >= 8'd1 && t <= 8'd15);
    f_nib = (f >= 8'd1 && f <= 8'd15);
    if (t_nib && f_nib && $urandom_range(0, 99) < 70) begin
      form = 0;
    end else begin
      do form = $urandom_range(1, 3);
      while ((form == 1 && !t_nib) || (form == 2 && !f_nib));
    end
    case (form)
      0: msg_q.push_back({t[3:0], f[3:0]});
      1: begin
        msg_q.push_back({t[3:0], 4'h0});
        msg_q.push_back(f);
      end
      2: begin
        msg_q.push_back({4'h0, f[3:0]});
        msg_q.push_back(t);
      end
      default: begin
        msg_q.push_back(8'h00);
        msg_q.push_back(t);
        msg_q.push_back(f);
      end
    endcase
  endtask

  task automatic put_field(input logic [7:0] t, input logic [7:0] f);
    int         n;
    int         pick;
    logic [7:0] lead;
    put_header(t, f);
    n = 0;
    case (t)
      TY_UINT8:   n = 1;
      TY_UINT16:  n = 2;
      TY_UINT32:  n = 4;
      TY_UINT64:  n = 8;
      TY_HASH128: n = 16;
      TY_HASH160: n = 20;
      TY_ACCOUNT: n = 21;
      TY_HASH256: n = 32;
      TY_AMOUNT: begin
        lead = 8'($urandom_range(0, 255));
        msg_q.push_back(lead);
        n = lead[7] ? 47 : 7;
      end
      TY_BLOB, TY_VECTOR256: begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          n = $urandom_range(0, 16);
          msg_q.push_back(8'(n));
        end else if (pick < 92) begin
          n = $urandom_range(17, 192);
          msg_q.push_back(8'(n));
        end else begin
          lead = 8'($urandom_range(0, 40));
          msg_q.push_back(8'd193);
          msg_q.push_back(lead);
          n = 193 + lead;
        end
      end
      default: n = 0;
    endcase
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_data_type();
    case ($urandom_range(0, 10))
      0:       return TY_UINT16;
      1:       return TY_UINT32;
      2:       return TY_UINT64;
      3:       return TY_HASH128;
      4:       return TY_HASH256;
      5:       return TY_AMOUNT;
      6:       return TY_BLOB;
      7:       return TY_ACCOUNT;
      8:       return TY_UINT8;
      9:       return TY_HASH160;
      default: return TY_VECTOR256;
    endcase
  endfunction

  task automatic build_wellformed();
    int         nf;
    int         pick;
    logic       k;
    logic [7:0] f;
    logic       kinds[$];
    nf = $urandom_range(1, 8);
    repeat (nf) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 && kinds.size() < 6) begin
        k = 1'($urandom_range(0, 1));
        do f = 8'($urandom_range(0, 255)); while (f == FIELD_END);
        put_header(k ? TY_ARRAY : TY_OBJECT, f);
        kinds.push_back(k);
      end else if (pick < 24 && kinds.size() > 0) begin
        k = kinds.pop_back();
        put_header(k ? TY_ARRAY : TY_OBJECT, FIELD_END);
      end else begin
        put_field(pick_data_type(), 8'($urandom_range(0, 255)));
      end
    end
    // unclosed nesting at the end is legal, so only close most of the time
    if ($urandom_range(0, 99) < 70) begin
      while (kinds.size() > 0) begin
        k = kinds.pop_back();
        put_header(k ? TY_ARRAY : TY_OBJECT, FIELD_END);
      end
    end
  endtask

  task automatic build_errored();
    logic [7:0] t;
    repeat ($urandom_range(0, 3)) put_field(pick_data_type(), 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 4))
      0: put_header(TY_NONE, 8'($urandom_range(0, 255)));
      1: put_header(TY_PATHSET, 8'($urandom_range(0, 255)));
      2: begin
        t = $urandom_range(0, 1) ? 8'($urandom_range(9, 13)) : 8'($urandom_range(20, 255));
        put_header(t, 8'($urandom_range(0, 255)));
      end
      3: put_header($urandom_range(0, 1) ? TY_ARRAY : TY_OBJECT, FIELD_END);
      default: begin
        put_header($urandom_range(0, 1) ? TY_VECTOR256 : TY_BLOB,
                   8'($urandom_range(0, 255)));
        msg_q.push_back(8'hFF);
      end
    endcase
    repeat ($urandom_range(0, 10)) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_message();
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      build_wellformed();
    end else if (pick < 80) begin
      build_wellformed();
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end else if (pick < 92) begin
      build_errored();
    end else begin
      repeat ($urandom_range(1, 20)) msg_q.push_back(8'($urandom_range(0, 255)));
    end
    gaps_on = ($urandom_range(0, 99) < 85);
    send_message();
  endtask

  // output held off while the input keeps offering back-to-back bytes
  task automatic stall_burst();
    drain_results();
    hold_off = 1'b1;
    gaps_on = 1'b0;
    put_field(TY_HASH256, 8'h05);
    put_field(TY_HASH256, 8'h06);
    send_message();
    drain_results();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    gaps_on = 1'b1;
    hold_off = 1'b0;
    bytes_sent = 0;
    messages = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // integers of every width, form-c uint8 header, empty blob at the end
    msg_q = '{8'h11, 8'h00, 8'h00, 8'h21, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h01, 8'h10, 8'h7F, 8'h71, 8'h00};
    send_message();
    msg_q = '{8'h31, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    // object and array around a native amount
    msg_q = '{8'hE2, 8'hF3, 8'h61, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h01, 8'hF1, 8'hE1};
    send_message();
    // issued amount
    msg_q = '{8'h61, 8'hC0};
    repeat (47) msg_q.push_back(8'hFF);
    send_message();
    // three-byte header, zero-length vector256
    msg_q = '{8'h00, 8'h13, 8'h01, 8'h00};
    send_message();
    // type zero, then an ignored byte
    msg_q = '{8'h00, 8'h00, 8'h05, 8'hAA};
    send_message();
    // close at depth zero
    msg_q = '{8'hE1};
    send_message();
    // pathset
    msg_q = '{8'h01, 8'h12, 8'h55};
    send_message();
    // unknown type
    msg_q = '{8'h91};
    send_message();
    // length prefix 255
    msg_q = '{8'h71, 8'hFF, 8'h00};
    send_message();
    // end inside a payload
    msg_q = '{8'h21, 8'h00};
    send_message();
    drain_results();

    // open until the combined depth limit, one open past it
    for (int i = 0; i < 256; i++) msg_q.push_back(i[0] ? 8'hF2 : 8'hE2);
    send_message();
    // two-byte length prefix, smallest value
    msg_q = '{8'h71, 8'hC1, 8'h00};
    repeat (193) msg_q.push_back(8'($urandom_range(0, 255)));
    send_message();
    // largest two- and three-byte prefixes, cut short
    msg_q = '{8'h71, 8'hF0, 8'hFF, 8'hAA};
    send_message();
    msg_q = '{8'h01, 8'h13, 8'hFE, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03};
    send_message();
    // smallest three-byte prefix, cut short inside the payload without gaps
    msg_q = '{8'h71, 8'hF1, 8'h00, 8'h00};
    repeat (40) msg_q.push_back(8'($urandom_range(0, 255)));
    gaps_on = 1'b0;
    send_message();
    gaps_on = 1'b1;

    stall_burst();

    while (bytes_sent < 1750) begin
      random_message();
      if (messages % 25 == 0) stall_burst();
    end

    drain_results();
    repeat (10) @(negedge clk);
    $display("tb summary: %0d messages, %0d bytes, %0d results compared, %0d mismatches",
             messages, bytes_sent, checked, fail_count);
    $display("tb summary: event kinds hit %b, error codes hit %b", ev_seen, err_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
